[hdl/blr_pkg.sv]
// shared types and constants of the line rasterizer
// no dependencies; imported by every module of the block
package blr_pkg;

    localparam int REG_W = 13;

    localparam logic [REG_W-1:0] WIN_W_RST = 13'd1920;
    localparam logic [REG_W-1:0] WIN_H_RST = 13'd1080;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        CFG_WIN_W = 1'b0,
        CFG_WIN_H = 1'b1
    } t_cfg_idx;

    // per-segment control bits carried from classifier to stepper
    typedef struct packed {
        logic ymaj;
        logic minor_neg;
    } t_seg_ctl;

endpackage

[hdl/bresenham_line_rasterizer.sv]
// Line rasterizer: each input item is a segment with signed center-relative endpoints; it
// produces min(|major delta|, MAX_SPAN) pixels, the far endpoint excluded, one per cycle from
// the stepping unit once the segment reaches it and while the output is not stalled; the
// stepping unit first loads the segment. The classifier works on the next segment and parks
// it in a two-entry queue meanwhile; a segment with no pixels is dropped by the classifier
// without entering the queue. Window size is written through the config port.
// depends on blr_pkg, blr_front, blr_queue, blr_back
module bresenham_line_rasterizer import blr_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int MAX_SPAN   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [REG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [COORD_BITS:0]  o_pixel_x,
    output logic signed [COORD_BITS:0]  o_pixel_y,
    output logic                        o_visible,
    output logic                        o_last,
    output logic                        o_truncated
);
    localparam int SEG_W = 2 + 3*COORD_BITS + 3*(COORD_BITS + 3);

    logic [REG_W-1:0] r_win_w, r_win_h;
    logic             q_push, q_full, q_pop, q_valid;
    logic [SEG_W-1:0] q_in, q_out;
    logic [COORD_BITS:0] pix_x, pix_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w <= WIN_W_RST;
            r_win_h <= WIN_H_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIN_W: r_win_w <= i_cfg_data;
                CFG_WIN_H: r_win_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    blr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_push     (q_push),
        .o_seg      (q_in),
        .i_full     (q_full)
    );

    blr_queue #(.WIDTH(SEG_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    blr_back #(.COORD_BITS(COORD_BITS), .MAX_SPAN(MAX_SPAN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_seg       (q_out),
        .o_pop       (q_pop),
        .i_win_w     (r_win_w),
        .i_win_h     (r_win_h),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_x   (pix_x),
        .o_pixel_y   (pix_y),
        .o_visible   (o_visible),
        .o_last      (o_last),
        .o_truncated (o_truncated)
    );

    assign o_pixel_x = pix_x;
    assign o_pixel_y = pix_y;

    // a cut run always ends on its last pixel
    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_last)
        else $error("truncated pixel not marked last");

    // inside a run the next pixel is ready right after one is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside a pixel run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

[hdl/blr_front.sv]
// segment classifier: takes endpoints, picks major axis, start point and error terms
// depends on blr_pkg; feeds blr_queue
module blr_front import blr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    output logic                        o_push,
    output logic [2+3*COORD_BITS+3*(COORD_BITS+3)-1:0] o_seg,
    input  logic                        i_full
);
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int EW = CW + 3;

    logic          r_ld_valid;
    logic [CW-1:0] r_xs, r_ys, r_xe, r_ye;
    logic [DW-1:0] r_dx, r_dy;

    logic [DW-1:0] adx_full, ady_full;
    logic [CW-1:0] adx, ady, dmaj, dmin;
    logic [CW-1:0] maj0, mn0;
    logic [EW-1:0] dmin2, err0, inc_step;
    logic          dx_neg, dy_neg, same, degenerate, accept;
    t_seg_ctl      ctl;

    always_comb begin
        dx_neg   = r_dx[DW-1];
        dy_neg   = r_dy[DW-1];
        adx_full = dx_neg ? (~r_dx + DW'(1)) : r_dx;
        ady_full = dy_neg ? (~r_dy + DW'(1)) : r_dy;
        adx      = adx_full[CW-1:0];
        ady      = ady_full[CW-1:0];
        ctl.ymaj = ady > adx;
        same     = (dx_neg && dy_neg) ||
                   (!dx_neg && (r_dx != '0) && !dy_neg && (r_dy != '0));
        ctl.minor_neg = !same;
        dmaj = ctl.ymaj ? ady : adx;
        dmin = ctl.ymaj ? adx : ady;
        // run starts at the endpoint with the smaller major coordinate
        if (!ctl.ymaj) begin
            maj0 = dx_neg ? r_xe : r_xs;
            mn0  = dx_neg ? r_ye : r_ys;
        end else begin
            maj0 = dy_neg ? r_ye : r_ys;
            mn0  = dy_neg ? r_xe : r_xs;
        end
        dmin2      = {2'b00, dmin, 1'b0};
        err0       = dmin2 - {3'b000, dmaj};
        inc_step   = dmin2 - {2'b00, dmaj, 1'b0};
        degenerate = (dmaj == '0);
    end

    // degenerate segments are dropped here without touching the queue
    assign o_push     = r_ld_valid && !degenerate && !i_full;
    assign o_in_ready = !r_ld_valid || degenerate || !i_full;
    assign o_seg      = {ctl, maj0, mn0, dmaj, err0, dmin2, inc_step};
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_ld_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xs <= i_x_start;
            r_ys <= i_y_start;
            r_xe <= i_x_end;
            r_ye <= i_y_end;
            r_dx <= {i_x_end[CW-1], i_x_end} - {i_x_start[CW-1], i_x_start};
            r_dy <= {i_y_end[CW-1], i_y_end} - {i_y_start[CW-1], i_y_start};
        end
    end

endmodule

[hdl/blr_queue.sv]
// short fifo between classifier and stepper
// depends on blr_pkg for the default depth; generic width and depth
module blr_queue import blr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hdl/blr_back.sv]
// pixel stepper: walks one classified segment a pixel per cycle, while the output register is free, into that register
// depends on blr_pkg; takes segments from blr_queue
module blr_back import blr_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int MAX_SPAN   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [2+3*COORD_BITS+3*(COORD_BITS+3)-1:0] i_seg,
    output logic                  o_pop,
    input  logic [REG_W-1:0]      i_win_w,
    input  logic [REG_W-1:0]      i_win_h,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS:0]   o_pixel_x,
    output logic [COORD_BITS:0]   o_pixel_y,
    output logic                  o_visible,
    output logic                  o_last,
    output logic                  o_truncated
);
    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 3;
    localparam int SUM_W = ((CW > REG_W - 1) ? CW : REG_W - 1) + 2;
    localparam int CNT_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    t_seg_ctl      seg_ctl, r_ctl;
    logic [CW-1:0] seg_maj, seg_mn, seg_dmaj;
    logic [EW-1:0] seg_err, seg_keep, seg_step;

    logic             r_busy, r_ov;
    logic [CW-1:0]    r_maj, r_mn, r_remain;
    logic [EW-1:0]    r_err, r_inc_keep, r_inc_step;
    logic [CNT_W-1:0] r_cnt;
    logic [CW:0]      r_px, r_py;
    logic             r_vis, r_last, r_trunc;

    logic             out_free, step, keep, last, trunc, vis;
    logic [CW-1:0]    mn_n, x_c, y_c;
    logic [EW-1:0]    err_n;
    logic [SUM_W-1:0] px, py;

    assign {seg_ctl, seg_maj, seg_mn, seg_dmaj, seg_err, seg_keep, seg_step} = i_seg;

    assign out_free = !r_ov || i_out_ready;
    assign step     = r_busy && out_free;
    assign o_pop    = !r_busy && i_q_valid;

    always_comb begin
        // y-major keeps the minor coordinate on a zero term, x-major does not
        keep  = r_ctl.ymaj ? (r_err[EW-1] || (r_err == '0)) : r_err[EW-1];
        err_n = r_err + (keep ? r_inc_keep : r_inc_step);
        if (keep) begin
            mn_n = r_mn;
        end else if (r_ctl.minor_neg) begin
            mn_n = r_mn - CW'(1);
        end else begin
            mn_n = r_mn + CW'(1);
        end
        x_c = r_ctl.ymaj ? mn_n : r_maj;
        y_c = r_ctl.ymaj ? r_maj : mn_n;
        px  = {{(SUM_W-CW){x_c[CW-1]}}, x_c} + {{(SUM_W-REG_W+1){1'b0}}, i_win_w[REG_W-1:1]};
        py  = {{(SUM_W-CW){y_c[CW-1]}}, y_c} + {{(SUM_W-REG_W+1){1'b0}}, i_win_h[REG_W-1:1]};
        vis = !px[SUM_W-1] && (px < {{(SUM_W-REG_W){1'b0}}, i_win_w}) &&
              !py[SUM_W-1] && (py < {{(SUM_W-REG_W){1'b0}}, i_win_h});
        last  = (r_remain == CW'(1)) || (r_cnt == CNT_W'(MAX_SPAN - 1));
        trunc = last && (r_remain != CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (step && last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl      <= seg_ctl;
            r_maj      <= seg_maj;
            r_mn       <= seg_mn;
            r_remain   <= seg_dmaj;
            r_err      <= seg_err;
            r_inc_keep <= seg_keep;
            r_inc_step <= seg_step;
            r_cnt      <= '0;
        end else if (step) begin
            r_maj    <= r_maj + CW'(1);
            r_mn     <= mn_n;
            r_remain <= r_remain - CW'(1);
            r_err    <= err_n;
            r_cnt    <= r_cnt + CNT_W'(1);
        end
        if (step) begin
            r_px    <= px[CW:0];
            r_py    <= py[CW:0];
            r_vis   <= vis;
            r_last  <= last;
            r_trunc <= trunc;
        end
    end

    assign o_out_valid = r_ov;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_visible   = r_vis;
    assign o_last      = r_last;
    assign o_truncated = r_trunc;

endmodule
